// ===== src/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the cursor sequence store.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_ADVANCE = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_ATTACH  = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_FULL       = 2'd1;
    localparam logic [1:0] ERR_NO_CURRENT = 2'd2;

    typedef struct packed {
        logic                 shift_up;
        logic                 shift_down;
        logic [IDX_W-1:0]     pos;
        logic [WORD_BITS-1:0] word;
    } t_cell_ctrl;

    typedef struct packed {
        logic             has;
        logic [IDX_W-1:0] idx;
    } t_cursor;

endpackage

// ===== src/csq_cell.sv =====
// ----------------------------------------------------------------------------
// csq_cell
// One storage slot of the sequence: holds a word, shifts toward either
// neighbor, and drives its word when the cursor points at it.
// ----------------------------------------------------------------------------
module csq_cell (
    input  logic                          i_clk,
    input  logic [csq_pkg::IDX_W-1:0]     i_index,
    input  csq_pkg::t_cell_ctrl           i_ctrl,
    input  csq_pkg::t_cursor              i_cursor,
    input  logic [csq_pkg::WORD_BITS-1:0] i_prev_word,
    input  logic [csq_pkg::WORD_BITS-1:0] i_next_word,
    output logic [csq_pkg::WORD_BITS-1:0] o_word,
    output logic [csq_pkg::WORD_BITS-1:0] o_sel_word
);
    import csq_pkg::*;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.shift_up) begin
            if (i_index > i_ctrl.pos) begin
                n_word = i_prev_word;
            end else if (i_index == i_ctrl.pos) begin
                n_word = i_ctrl.word;
            end
        end else if (i_ctrl.shift_down) begin
            if (i_index >= i_ctrl.pos) begin
                n_word = i_next_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_sel_word = (i_cursor.has && (i_cursor.idx == i_index)) ? r_word : '0;

endmodule

// ===== src/cursor_sequence_store.sv =====
// A result is registered in the store state, then in the output registers.
// Throughput: one operation per cycle while the output is not stalled;
// the row of cells shifts all entries at once, and the cursor word is
// gathered from the cells as the result moves into the output registers.
// Reset: entry count and cursor clear, the pipeline empties; the cell
// contents are not reset.
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Ordered word store with a cursor, built as a row of shifting cells.
// ----------------------------------------------------------------------------
module cursor_sequence_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_operation,
    input  logic [csq_pkg::WORD_BITS-1:0] i_entry_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [csq_pkg::WORD_BITS-1:0] o_current_word,
    output logic                          o_has_current,
    output logic [csq_pkg::CNT_W-1:0]     o_entry_count,
    output logic [1:0]                    o_error_code
);
    import csq_pkg::*;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_cursor;
    logic [CNT_W-1:0]     n_cursor;
    logic [1:0]           r_err;
    logic [1:0]           n_err;
    logic                 r_pend;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    logic                 r_out_has;
    logic [CNT_W-1:0]     r_out_count;
    logic [1:0]           r_out_err;

    logic                 accept;
    logic                 move;
    logic                 has;
    logic                 full;
    logic [IDX_W-1:0]     pos;
    t_cell_ctrl           ctrl;
    t_cursor              cursor;
    logic [WORD_BITS-1:0] gathered;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] sel_word  [CAPACITY];

    assign move    = r_pend && (!r_out_valid || !i_stall);
    assign o_stall = r_pend && !move;
    assign accept  = i_valid && !o_stall;

    assign has  = (r_cursor != '0);
    assign full = (r_count >= CNT_W'(CAPACITY));

    always_comb begin
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_err      = ERR_OK;
        pos        = '0;
        ctrl       = '0;
        ctrl.word  = i_entry_value;
        unique case (i_operation)
            OP_START: begin
                n_cursor = (r_count != '0) ? CNT_W'(1) : '0;
            end
            OP_ADVANCE: begin
                if (!has) begin
                    n_err = ERR_NO_CURRENT;
                end else if (r_cursor >= r_count) begin
                    n_cursor = '0;
                end else begin
                    n_cursor = r_cursor + CNT_W'(1);
                end
            end
            OP_INSERT, OP_ATTACH: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    if (i_operation == OP_INSERT) begin
                        pos = has ? IDX_W'(r_cursor - CNT_W'(1)) : '0;
                    end else begin
                        pos = has ? IDX_W'(r_cursor) : IDX_W'(r_count);
                    end
                    ctrl.shift_up = accept;
                    n_count       = r_count + CNT_W'(1);
                    n_cursor      = CNT_W'(pos) + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!has) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    pos             = IDX_W'(r_cursor - CNT_W'(1));
                    ctrl.shift_down = accept;
                    n_count         = r_count - CNT_W'(1);
                    if (CNT_W'(pos) >= n_count) begin
                        n_cursor = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        ctrl.pos = pos;
    end

    assign cursor.has = has;
    assign cursor.idx = IDX_W'(r_cursor - CNT_W'(1));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] prev_word;
        logic [WORD_BITS-1:0] next_word;

        if (g == 0) begin : g_first
            assign prev_word = '0;
        end else begin : g_mid_lo
            assign prev_word = cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_mid_hi
            assign next_word = cell_word[g+1];
        end

        csq_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(g)),
            .i_ctrl      (ctrl),
            .i_cursor    (cursor),
            .i_prev_word (prev_word),
            .i_next_word (next_word),
            .o_word      (cell_word[g]),
            .o_sel_word  (sel_word[g])
        );
    end

    always_comb begin
        gathered = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            gathered = gathered | sel_word[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
                r_err    <= n_err;
                r_pend   <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_word  <= gathered;
            r_out_has   <= has;
            r_out_count <= r_count;
            r_out_err   <= r_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_current_word = r_out_word;
    assign o_has_current  = r_out_has;
    assign o_entry_count  = r_out_count;
    assign o_error_code   = r_out_err;

endmodule
